// ----- rtl/smoothed_coefficient_biquad_filter_top_defines.svh -----
// assertion macros used by the port-level checker of the smoothed biquad filter
`ifndef SMOOTHED_COEFFICIENT_BIQUAD_FILTER_TOP_DEFINES_SVH
`define SMOOTHED_COEFFICIENT_BIQUAD_FILTER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define SBQF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SBQF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define SBQF_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sbqf_pkg.sv -----
// types, widths and step constants of the smoothed-coefficient biquad filter
`default_nettype none

package sbqf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = COEF_W - 4;
    localparam int GLIDE_W    = 17;
    localparam int GLIDE_FRAC = 16;

    localparam int NUM_COEF   = 5;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);

    localparam int DIFF_W  = COEF_W + 1;
    localparam int MAX_AS  = (DIFF_W > SAMPLE_W) ? DIFF_W : SAMPLE_W;
    localparam int MUL_W   = (MAX_AS > GLIDE_W + 1) ? MAX_AS : GLIDE_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = SAMPLE_W + COEF_W + 3;
    localparam int YFULL_W = ACC_W - COEF_FRAC;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COEF_W > GLIDE_W) ? COEF_W : GLIDE_W;

    localparam logic [GLIDE_W-1:0] GLIDE_ONE = GLIDE_W'(1) << GLIDE_FRAC;
    localparam logic [COEF_W-1:0]  COEF_ONE  = COEF_W'(1) << COEF_FRAC;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_A2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLIDE     = 3'd5;

    // coefficient / tap slots
    localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd4;

    // sequencer step plan
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_UPD_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FILT_FIRST = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FILT_LAST = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ACC_FIRST = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ACC_SUB = 4'd9;
    localparam logic [STEP_W-1:0] STEP_ACC_LAST = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FINAL = 4'd11;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } sbqf_state_t;

    typedef struct packed {
        logic                  load;
        logic                  mul_glide;
        logic [COEF_IDX_W-1:0] mul_idx;
        logic                  upd_en;
        logic [COEF_IDX_W-1:0] upd_idx;
        logic                  acc_clr;
        logic                  acc_en;
        logic                  acc_sub;
        logic                  commit;
    } sbqf_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sbqf_ctrl.sv -----
// step sequencer that schedules the shared multiplier for glide and filter terms
`default_nettype none

module sbqf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              out_free,
    output sbqf_pkg::sbqf_ctl_t    ctl
);
    import sbqf_pkg::*;

    sbqf_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] filt_off;

    assign filt_off = step_reg - STEP_FILT_FIRST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load    = 1'b1;
                    ctl.acc_clr = 1'b1;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                // glide products first, then the five filter taps
                if (step_reg < STEP_FILT_FIRST) begin
                    ctl.mul_glide = 1'b1;
                    ctl.mul_idx   = step_reg[COEF_IDX_W-1:0];
                end else if (step_reg <= STEP_FILT_LAST) begin
                    ctl.mul_idx = filt_off[COEF_IDX_W-1:0];
                end
                if (step_reg >= STEP_UPD_FIRST && step_reg <= STEP_FILT_FIRST) begin
                    ctl.upd_en  = 1'b1;
                    ctl.upd_idx = COEF_IDX_W'(step_reg - STEP_UPD_FIRST);
                end
                if (step_reg >= STEP_ACC_FIRST && step_reg <= STEP_ACC_LAST) begin
                    ctl.acc_en  = 1'b1;
                    ctl.acc_sub = (step_reg >= STEP_ACC_SUB);
                end
                if (step_reg == STEP_FINAL) begin
                    // hold here until the output register can take the beat
                    if (out_free) begin
                        ctl.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sbqf_mac.sv -----
// shared multiplier with registered product, accumulator, rounding and saturation
`default_nettype none

module sbqf_mac (
    input  wire logic                                     aclk,
    input  wire sbqf_pkg::sbqf_ctl_t                      ctl,
    input  wire logic signed [sbqf_pkg::MUL_W-1:0]        op_a,
    input  wire logic signed [sbqf_pkg::MUL_W-1:0]        op_b,
    output logic signed [sbqf_pkg::PROD_W-1:0]            prod,
    output logic signed [sbqf_pkg::SAMPLE_W-1:0]          y_sat,
    output logic                                          y_clip
);
    import sbqf_pkg::*;

    localparam logic signed [YFULL_W-1:0] Y_HI = YFULL_W'(SAMPLE_MAX);
    localparam logic signed [YFULL_W-1:0] Y_LO = YFULL_W'(SAMPLE_MIN);
    localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [YFULL_W-1:0] y_full;

    assign term = ACC_W'(prod_reg);
    assign prod = prod_reg;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.acc_clr) begin
            acc_next = '0;
        end else if (ctl.acc_en) begin
            acc_next = ctl.acc_sub ? acc_reg - term : acc_reg + term;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    // round half up, then clamp to the sample range
    assign acc_rnd = acc_reg + RND_HALF;
    assign y_full  = acc_rnd[ACC_W-1:COEF_FRAC];

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_full[SAMPLE_W-1:0];
        if (y_full > Y_HI) begin
            y_sat  = SAMPLE_MAX;
            y_clip = 1'b1;
        end else if (y_full < Y_LO) begin
            y_sat  = SAMPLE_MIN;
            y_clip = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/smoothed_coefficient_biquad_filter_top.sv -----
// top level of the smoothed-coefficient direct-form-I biquad filter
//
//  channel | direction | beat
//  s_*     | in        | one signed Q1.23 sample (s_sample_in)
//  m_*     | out       | one filtered sample and clip flag (m_sample_out, m_clipped)
//  cfg_*   | in        | register index and data (targets b0..a2, glide factor)
//
// one sample at a time from s_ accept to the m_ beat, set by the single shared
// multiplier: five glide products then five taps
// s_ready is low while a sample is in flight; it returns when the result enters m_
// a stalled m_ holds its beat and the last step waits until the output register frees
// synchronous active-low reset restores unity b0, zero taps and a jump glide factor
// cfg_ready is always high; writes are expected only while no sample is in flight
`default_nettype none

module smoothed_coefficient_biquad_filter_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [sbqf_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [sbqf_pkg::SAMPLE_W-1:0]        m_sample_out,
    output logic                                        m_clipped,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sbqf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [sbqf_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import sbqf_pkg::*;

    sbqf_ctl_t ctl;

    logic signed [COEF_W-1:0]   target_reg  [NUM_COEF];
    logic signed [COEF_W-1:0]   working_reg [NUM_COEF];
    logic signed [SAMPLE_W-1:0] tap_reg     [NUM_COEF];
    logic [GLIDE_W-1:0]         glide_reg;
    logic signed [COEF_W-1:0]   hold_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_clipped_reg;

    logic [GLIDE_W-1:0]         factor;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [MUL_W-1:0]    op_a, op_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [COEF_W-1:0]   working_next;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       y_clip;
    logic                       out_free;

    assign cfg_ready    = 1'b1;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_clipped    = m_clipped_reg;

    sbqf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // factors above one act as a jump
    assign factor = (glide_reg > GLIDE_ONE) ? GLIDE_ONE : glide_reg;
    assign diff   = DIFF_W'(target_reg[ctl.mul_idx]) - DIFF_W'(working_reg[ctl.mul_idx]);

    always_comb begin
        if (ctl.mul_glide) begin
            op_a = MUL_W'(diff);
            op_b = MUL_W'(signed'({1'b0, factor}));
        end else begin
            op_a = MUL_W'(working_reg[ctl.mul_idx]);
            op_b = MUL_W'(tap_reg[ctl.mul_idx]);
        end
    end

    sbqf_mac u_mac (
        .aclk   (aclk),
        .ctl    (ctl),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod   (prod),
        .y_sat  (y_sat),
        .y_clip (y_clip)
    );

    // step never overshoots the target, so the low bits of the sum are exact
    assign prod_rnd     = prod + (PROD_W'(1) <<< (GLIDE_FRAC - 1));
    assign working_next = hold_reg + prod_rnd[GLIDE_FRAC +: COEF_W];

    always_ff @(posedge aclk) begin
        if (ctl.mul_glide) begin
            hold_reg <= working_reg[ctl.mul_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                target_reg[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
            end
            glide_reg <= GLIDE_ONE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TARGET_B0: target_reg[COEF_B0] <= cfg_data[COEF_W-1:0];
                REG_TARGET_B1: target_reg[COEF_B1] <= cfg_data[COEF_W-1:0];
                REG_TARGET_B2: target_reg[COEF_B2] <= cfg_data[COEF_W-1:0];
                REG_TARGET_A1: target_reg[COEF_A1] <= cfg_data[COEF_W-1:0];
                REG_TARGET_A2: target_reg[COEF_A2] <= cfg_data[COEF_W-1:0];
                REG_GLIDE:     glide_reg           <= cfg_data[GLIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                working_reg[i] <= (i == int'(COEF_B0)) ? COEF_ONE : '0;
            end
        end else if (ctl.upd_en) begin
            working_reg[ctl.upd_idx] <= working_next;
        end
    end

    // taps: current input, two past inputs, two past outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (ctl.load) begin
            tap_reg[COEF_B0] <= s_sample_in;
        end else if (ctl.commit) begin
            tap_reg[COEF_B2] <= tap_reg[COEF_B1];
            tap_reg[COEF_B1] <= tap_reg[COEF_B0];
            tap_reg[COEF_A2] <= tap_reg[COEF_A1];
            tap_reg[COEF_A1] <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            m_sample_reg  <= y_sat;
            m_clipped_reg <= y_clip;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sbqf_checker.sv -----
// port-level checker for the smoothed biquad filter, bound to the top level
`default_nettype none
`include "smoothed_coefficient_biquad_filter_top_defines.svh"

module sbqf_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_valid,
    input wire logic                                  s_ready,
    input wire logic                                  m_valid,
    input wire logic                                  m_ready,
    input wire logic signed [sbqf_pkg::SAMPLE_W-1:0]  m_sample_out,
    input wire logic                                  m_clipped
);
    import sbqf_pkg::*;

    logic                at_bound;
    logic [SAMPLE_W:0]   beat_bits;

    assign at_bound  = (m_sample_out == SAMPLE_MAX) || (m_sample_out == SAMPLE_MIN);
    assign beat_bits = {m_clipped, m_sample_out};

    `SBQF_ASSERT_RST(a_reset_state, !aresetn, !m_valid && s_ready, "reset left a beat or busy")
    `SBQF_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "took a second sample")
    `SBQF_ASSERT_NXT(a_no_early_result, s_valid && s_ready && !m_valid, !m_valid, "result too early")
    `SBQF_ASSERT_IMP(a_clip_at_bound, m_valid && m_clipped, at_bound, "clip flag off bound")
    `SBQF_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(beat_bits), "stalled beat changed")

endmodule

bind smoothed_coefficient_biquad_filter_top sbqf_checker u_sbqf_checker (.*);

`default_nettype wire

// ----- tb/tb_smoothed_coefficient_biquad_filter_top.sv -----
// self-checking testbench of the smoothed-coefficient biquad filter top level
`default_nettype none

module tb_smoothed_coefficient_biquad_filter_top;
    import sbqf_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int MAX_GAP       = 5;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 95;
    localparam int COEF_SPAN     = 1 << COEF_FRAC;
    localparam int LIMIT_CYCLES  = 400_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filtered_beat_t;

    // holds its own copy of targets, working coefficients and taps
    class biquad_scoreboard;
        logic signed [COEF_W-1:0] target [NUM_COEF];
        logic [GLIDE_W-1:0]       glide;
        longint                   working [NUM_COEF];
        longint                   x1, x2, y1, y2;
        filtered_beat_t           expected_beats [$];
        int                       errors;
        int                       seen;

        function new();
            int k;
            for (k = 0; k < NUM_COEF; k++) begin
                target[k]  = '0;
                working[k] = 0;
            end
            target[COEF_B0]  = COEF_ONE;
            working[COEF_B0] = longint'(COEF_ONE);
            glide  = GLIDE_ONE;
            x1     = 0;
            x2     = 0;
            y1     = 0;
            y2     = 0;
            errors = 0;
            seen   = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_B0: target[COEF_B0] = data[COEF_W-1:0];
                REG_TARGET_B1: target[COEF_B1] = data[COEF_W-1:0];
                REG_TARGET_B2: target[COEF_B2] = data[COEF_W-1:0];
                REG_TARGET_A1: target[COEF_A1] = data[COEF_W-1:0];
                REG_TARGET_A2: target[COEF_A2] = data[COEF_W-1:0];
                REG_GLIDE:     glide = data[GLIDE_W-1:0];
                default: ;
            endcase
        endfunction

        // one-pole step, rounded half up; stalls when the rounded step is zero
        function longint glide_toward(longint work, logic signed [COEF_W-1:0] tgt, longint f);
            longint diff;
            diff = longint'(tgt) - work;
            return work + ((diff * f + (longint'(1) <<< (GLIDE_FRAC - 1))) >>> GLIDE_FRAC);
        endfunction

        function void note_input(logic signed [SAMPLE_W-1:0] x);
            longint         f;
            longint         acc;
            longint         y;
            filtered_beat_t beat;
            int             k;
            f = (glide > GLIDE_ONE) ? longint'(GLIDE_ONE) : longint'(glide);
            for (k = 0; k < NUM_COEF; k++)
                working[k] = glide_toward(working[k], target[k], f);
            acc = working[COEF_B0] * longint'(x) + working[COEF_B1] * x1
                + working[COEF_B2] * x2 - working[COEF_A1] * y1 - working[COEF_A2] * y2
                + (longint'(1) <<< (COEF_FRAC - 1));
            y = acc >>> COEF_FRAC;
            beat.clipped = 1'b0;
            if (y > longint'(SAMPLE_MAX)) begin
                y = longint'(SAMPLE_MAX);
                beat.clipped = 1'b1;
            end
            if (y < longint'(SAMPLE_MIN)) begin
                y = longint'(SAMPLE_MIN);
                beat.clipped = 1'b1;
            end
            beat.sample = y[SAMPLE_W-1:0];
            x2 = x1;
            x1 = longint'(x);
            y2 = y1;
            y1 = y;
            expected_beats.push_back(beat);
        endfunction

        task check_result(logic signed [SAMPLE_W-1:0] sample, logic clipped);
            filtered_beat_t beat;
            seen++;
            if (expected_beats.size() == 0) begin
                report($sformatf("output beat %0d (%0d) with no sample pending", seen, sample));
                return;
            end
            beat = expected_beats.pop_front();
            if (sample !== beat.sample)
                report($sformatf("beat %0d sample_out %0d, predicted %0d",
                                 seen, sample, beat.sample));
            if (clipped !== beat.clipped)
                report($sformatf("beat %0d clipped %b, predicted %b",
                                 seen, clipped, beat.clipped));
        endtask

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       m_clipped;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    biquad_scoreboard           sb;
    bit                         calm;
    logic signed [SAMPLE_W-1:0] last_sample;

    smoothed_coefficient_biquad_filter_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_result(m_sample_out, m_clipped);
    end

    // result side: a fresh stall draw for every beat
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_input(x);
        last_sample = x;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                  input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                                  input logic [COEF_W-1:0] a2,
                                  input logic [CFG_DATA_W-1:0] glide_word);
        write_reg(REG_TARGET_B0, CFG_DATA_W'(b0));
        write_reg(REG_TARGET_B1, CFG_DATA_W'(b1));
        write_reg(REG_TARGET_B2, CFG_DATA_W'(b2));
        write_reg(REG_TARGET_A1, CFG_DATA_W'(a1));
        write_reg(REG_TARGET_A2, CFG_DATA_W'(a2));
        write_reg(REG_GLIDE, glide_word);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ($urandom_range(0, 1) == 1) ? COEF_MAX : COEF_MIN;
        if (r <= 2)
            return COEF_W'($urandom);
        return COEF_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic [GLIDE_W-1:0] pick_glide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GLIDE_ONE;
            2:       return GLIDE_W'($urandom_range(1, 4096));
            3:       return GLIDE_W'($urandom_range(0, 65536));
            4:       return GLIDE_W'($urandom_range(65537, 131071));
            default: return GLIDE_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3, 4:    return SAMPLE_W'($urandom_range(0, 2000) - 1000);
            5, 6:    return last_sample;  // dc stretch lets the glide settle
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int                    phase;
        int                    n;
        logic [CFG_DATA_W-1:0] glide_word;
        sb          = new();
        calm        = 1'b0;
        last_sample = '0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings pass the sample straight through
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'h555555);
        send_sample(24'haaaaaa);
        drain_results();

        // one-lsb gain puts the output exactly on the rounding halfway point
        program_filter(COEF_W'(1), '0, '0, '0, '0, CFG_DATA_W'(GLIDE_ONE));
        send_sample(24'sd524288);
        send_sample(-24'sd524288);
        send_sample(-24'sd524289);
        drain_results();

        // extreme taps with a factor above one, driving saturation both ways
        program_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, CFG_DATA_W'(131071));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_results();

        // unused indexes must leave everything alone
        write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));

        // zero factor freezes the working set at the extremes
        program_filter(COEF_ONE, '0, '0, '0, '0, '0);
        send_sample(24'sd1000);
        send_sample(-24'sd1000);
        drain_results();

        program_filter(COEF_ONE, '0, '0, '0, '0, CFG_DATA_W'(70000));
        send_sample(24'sd123456);
        send_sample(-24'sd654321);
        drain_results();

        // a one-lsb difference at the smallest factor never moves
        program_filter(COEF_ONE + 1'b1, '0, '0, '0, '0, CFG_DATA_W'(1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_results();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm       = (phase % 3 == 2);
            glide_word = CFG_DATA_W'(pick_glide());
            if ($urandom_range(0, 3) == 0)
                glide_word[CFG_DATA_W-1:GLIDE_W] = (CFG_DATA_W - GLIDE_W)'($urandom);
            program_filter(pick_coef(COEF_SPAN), pick_coef(COEF_SPAN), pick_coef(COEF_SPAN),
                           pick_coef(2 * COEF_SPAN), pick_coef(COEF_SPAN - 1), glide_word);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample());
            drain_results();
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire
